@@ src/fpp_pkg.sv @@
package fpp_pkg;

    // Sizing
    localparam int WINDOW_DEF = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int TIME_W     = 31;
    localparam int AMT_W      = 32;
    localparam int PID_W      = 34;   // P + I + D
    localparam int BASE_W     = 35;   // P + I + D - overshoot
    localparam int PMO_W      = 33;   // period - overshoot
    localparam int ADJ_W      = 36;   // sleep adjust before saturation

    // Item opcodes
    localparam logic OP_FRAME_END = 1'b0;
    localparam logic OP_WAKE      = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_SLEEP   = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_IGNORED = 2'd2;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 4'd3;

    localparam logic [TIME_W-1:0] PERIOD_RESET = 31'd16667;

    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

    // Precomputed controller terms, valid when fresh is set
    typedef struct packed {
        logic                     fresh;
        logic signed [PID_W-1:0]  pid;
        logic signed [BASE_W-1:0] base;
        logic signed [PMO_W-1:0]  pmo;
    } terms_t;

    // Error ring read side
    typedef struct packed {
        logic               ok;
        logic signed [31:0] old;
    } ring_stat_t;

    // Saturate to 32 bit signed
    function automatic logic signed [31:0] sat32(input logic signed [ADJ_W-1:0] v);
        logic signed [ADJ_W-1:0] hi_lim;
        logic signed [ADJ_W-1:0] lo_lim;
        hi_lim = ADJ_W'(MAX32);
        lo_lim = ADJ_W'(MIN32);
        if (v > hi_lim)
        begin
            return MAX32;
        end
        else if (v < lo_lim)
        begin
            return MIN32;
        end
        return v[31:0];
    endfunction

endpackage

@@ src/fpp_if.sv @@
interface fpp_item_if;
    import fpp_pkg::*;
    logic              valid;
    logic              ready;
    logic              op;
    logic [TIME_W-1:0] elapsed;
    modport source (output valid, op, elapsed, input ready);
    modport sink   (input valid, op, elapsed, output ready);
endinterface

interface fpp_result_if;
    import fpp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic signed [AMT_W-1:0] amount;
    modport source (output valid, kind, amount, input ready);
    modport sink   (input valid, kind, amount, output ready);
endinterface

interface fpp_cfg_if;
    import fpp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/fpp_ring.sv @@
module fpp_ring #(
    parameter int WINDOW = fpp_pkg::WINDOW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic signed [31:0]  push_data,
    output fpp_pkg::ring_stat_t stat
);
    import fpp_pkg::*;

    localparam int PTR_W = $clog2(WINDOW);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [WINDOW-1:0]  valid_reg, valid_next;
    logic signed [31:0] ring_mem [WINDOW];
    logic signed [31:0] rd_data_reg;
    logic               rd_valid_reg;
    logic               ok_reg;

    // Write pointer and per-entry valid bits
    always_comb
    begin
        ptr_next   = ptr_reg;
        valid_next = valid_reg;
        if (push)
        begin
            ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
            valid_next[ptr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            ok_reg       <= 1'b1;
        end
        else
        begin
            ptr_reg      <= ptr_next;
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[ptr_reg];
            // ok is low until read data follows the moved pointer
            ok_reg       <= !push;
        end
    end

    // Ring memory: write at the pointer, registered read of the same slot
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ring_mem[ptr_reg] <= push_data;
        end
        rd_data_reg <= ring_mem[ptr_reg];
    end

    // Never-written entries read as zero
    assign stat.ok  = ok_reg;
    assign stat.old = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ src/fpp_qmul.sv @@
module fpp_qmul #(
    parameter int X_W = 33
) (
    input  logic                  clk,
    input  logic signed [31:0]    gain,
    input  logic signed [X_W-1:0] x,
    output logic signed [31:0]    term
);
    import fpp_pkg::*;

    localparam int HI_W  = X_W - 32;
    localparam int HP_W  = 32 + HI_W;
    localparam int MAG_W = 49;

    // Stage 0: magnitudes and sign
    logic             neg_s0_reg;
    logic [31:0]      ua_s0_reg;
    logic [X_W-1:0]   ub_s0_reg;
    // Stage 1: partial products
    logic             neg_s1_reg;
    logic [63:0]      lo_s1_reg;
    logic [HP_W-1:0]  hi_s1_reg;
    // Stage 2: Q16 magnitude
    logic             neg_s2_reg;
    logic             big_s2_reg;
    logic [MAG_W-1:0] mag_s2_reg;
    // Stage 3: signed, saturated
    logic signed [31:0] term_reg;
    logic signed [31:0] term_next;
    logic               cap_pos;
    logic               cap_neg;

    always_ff @(posedge clk)
    begin
        neg_s0_reg <= gain[31] ^ x[X_W-1];
        ua_s0_reg  <= gain[31] ? 32'(-gain) : 32'(gain);
        ub_s0_reg  <= x[X_W-1] ? X_W'(-x) : X_W'(x);
    end

    always_ff @(posedge clk)
    begin
        neg_s1_reg <= neg_s0_reg;
        lo_s1_reg  <= 64'(ua_s0_reg) * 64'(ub_s0_reg[31:0]);
        hi_s1_reg  <= HP_W'(ua_s0_reg) * HP_W'(ub_s0_reg[X_W-1:32]);
    end

    // Upper partial product of 2^15 or more saturates in any case
    always_ff @(posedge clk)
    begin
        neg_s2_reg <= neg_s1_reg;
        big_s2_reg <= |hi_s1_reg[HP_W-1:15];
        mag_s2_reg <= {18'b0, hi_s1_reg[14:0], 16'b0} + {1'b0, lo_s1_reg[63:16]};
    end

    // Saturate and apply sign
    always_comb
    begin
        cap_pos = big_s2_reg || (|mag_s2_reg[MAG_W-1:31]);
        cap_neg = big_s2_reg || (|mag_s2_reg[MAG_W-1:32])
                  || (mag_s2_reg[31] && (|mag_s2_reg[30:0]));
        if (neg_s2_reg)
        begin
            term_next = cap_neg ? MIN32 : -$signed(mag_s2_reg[31:0]);
        end
        else
        begin
            term_next = cap_pos ? MAX32 : $signed(mag_s2_reg[31:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
    end

    assign term = term_reg;

endmodule

@@ src/fpp_terms.sv @@
module fpp_terms #(
    parameter int SUM_W = 36
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        refresh,
    input  logic signed [31:0]          gain_p,
    input  logic signed [31:0]          gain_i,
    input  logic signed [31:0]          gain_d,
    input  logic [fpp_pkg::TIME_W-1:0]  frame_period,
    input  logic signed [31:0]          newest_error,
    input  logic signed [SUM_W-1:0]     error_sum,
    input  logic signed [32:0]          error_step,
    input  logic signed [31:0]          overshoot,
    output fpp_pkg::terms_t             terms
);
    import fpp_pkg::*;

    // four multiplier stages plus the combine stage
    localparam int LAT   = 5;
    localparam int CNT_W = $clog2(LAT + 1);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(LAT);

    logic signed [31:0]       term_p, term_i, term_d;
    logic signed [PID_W-1:0]  pid_reg;
    logic signed [BASE_W-1:0] base_reg;
    logic signed [PMO_W-1:0]  pmo_reg;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    fpp_qmul #(.X_W(33)) u_mul_p (
        .clk  (clk),
        .gain (gain_p),
        .x    (33'(newest_error)),
        .term (term_p)
    );

    fpp_qmul #(.X_W(SUM_W)) u_mul_i (
        .clk  (clk),
        .gain (gain_i),
        .x    (error_sum),
        .term (term_i)
    );

    fpp_qmul #(.X_W(33)) u_mul_d (
        .clk  (clk),
        .gain (gain_d),
        .x    (error_step),
        .term (term_d)
    );

    // Combine terms with the carried overshoot
    always_ff @(posedge clk)
    begin
        pid_reg  <= PID_W'(term_p) + PID_W'(term_i) + PID_W'(term_d);
        base_reg <= BASE_W'(term_p) + BASE_W'(term_i) + BASE_W'(term_d)
                    - BASE_W'(overshoot);
        pmo_reg  <= PMO_W'($signed({1'b0, frame_period})) - PMO_W'(overshoot);
    end

    // Staleness count: terms are good once the pipeline has flushed
    always_comb
    begin
        if (refresh)
        begin
            cnt_next = CNT_LOAD;
        end
        else if (cnt_reg == '0)
        begin
            cnt_next = '0;
        end
        else
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_LOAD;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign terms.fresh = (cnt_reg == '0);
    assign terms.pid   = pid_reg;
    assign terms.base  = base_reg;
    assign terms.pmo   = pmo_reg;

endmodule

@@ src/frame_pacing_pid.sv @@
// Frame pacer with a PID loop over a windowed error history.
//
// Channels (valid/ready, a transaction moves on an edge with both high):
//   item   : op (frame end or wake) and elapsed ticks since frame start.
//   result : kind (sleep request, frame step done, unexpected wake) and amount.
//   cfg    : index/data register writes, always ready; write only while idle.
//
// Flow: an accepted item waits in the execute slot until the output register is
// free and the ring read and (for a frame end) the gain terms are ready; its
// result is then registered in the output register.
// Throughput: one item per cycle while no controller state changes and results
// are taken. An item that pushes an error (or a cfg write) restarts the
// five-stage gain product pipeline, so a following frame end waits until it has
// flushed; a wake straight after a push waits for the ring memory read.
// Reset: control state and config return to defaults (period 16667, gains 0);
// payload is not reset; ring entries read zero until written, no clearing pass.
// Stall: a held result keeps the output register; one more item is accepted
// into the execute slot and waits there until the result is taken.
module frame_pacing_pid #(
    parameter int WINDOW = fpp_pkg::WINDOW_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    fpp_item_if.sink     item,
    fpp_result_if.source result,
    fpp_cfg_if.sink      cfg
);
    import fpp_pkg::*;

    localparam int SUM_W = 32 + $clog2(WINDOW);

    // Configuration
    logic [TIME_W-1:0]  period_reg, period_next;
    logic signed [31:0] gain_p_reg, gain_p_next;
    logic signed [31:0] gain_i_reg, gain_i_next;
    logic signed [31:0] gain_d_reg, gain_d_next;
    logic               cfg_fire;

    // Controller state
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [31:0]      newest_reg, newest_next;
    logic signed [32:0]      step_reg, step_next;
    logic signed [31:0]      ovs_reg, ovs_next;
    logic signed [31:0]      pending_reg, pending_next;
    logic                    waiting_reg, waiting_next;

    // Execute slot
    logic               x_valid_reg;
    logic               x_op_reg;
    logic [TIME_W-1:0]  x_elapsed_reg;
    logic signed [31:0] x_idle_reg;

    // Output register
    logic               o_valid_reg;
    logic [1:0]         o_kind_reg, o_kind_next;
    logic signed [31:0] o_amount_reg, o_amount_next;

    logic               item_fire, x_fire, out_free, can_go;
    logic               clamp, sleep, push, refresh;
    logic signed [ADJ_W-1:0] adj_open, adj, ovs_wake_w, ovs_frame_w;
    terms_t             terms;
    ring_stat_t         ring_stat;

    fpp_ring #(.WINDOW(WINDOW)) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (x_idle_reg),
        .stat      (ring_stat)
    );

    fpp_terms #(.SUM_W(SUM_W)) u_terms (
        .clk          (clk),
        .rst_n        (rst_n),
        .refresh      (refresh),
        .gain_p       (gain_p_reg),
        .gain_i       (gain_i_reg),
        .gain_d       (gain_d_reg),
        .frame_period (period_reg),
        .newest_error (newest_reg),
        .error_sum    (sum_reg),
        .error_step   (step_reg),
        .overshoot    (ovs_reg),
        .terms        (terms)
    );

    // Handshakes
    assign cfg.ready    = 1'b1;
    assign cfg_fire     = cfg.valid && cfg.ready;
    assign out_free     = !o_valid_reg || result.ready;
    assign can_go       = ring_stat.ok && (x_op_reg == OP_WAKE || terms.fresh);
    assign x_fire       = x_valid_reg && out_free && can_go;
    assign item.ready   = !x_valid_reg || x_fire;
    assign item_fire    = item.valid && item.ready;
    assign refresh      = push || cfg_fire;

    // Delay: clamp to the period exactly when P + I + D exceeds elapsed
    always_comb
    begin
        clamp       = $signed(terms.pid) > $signed({3'b0, x_elapsed_reg});
        adj_open    = ADJ_W'(x_idle_reg) + ADJ_W'($signed(terms.base));
        adj         = clamp ? ADJ_W'($signed(terms.pmo)) : adj_open;
        sleep       = !adj[ADJ_W-1] && (adj != '0);
        ovs_wake_w  = ADJ_W'($signed({1'b0, x_elapsed_reg})) - ADJ_W'(pending_reg);
        ovs_frame_w = ADJ_W'(ovs_reg) - ADJ_W'(x_idle_reg);
    end

    // Execute
    always_comb
    begin
        ovs_next      = ovs_reg;
        pending_next  = pending_reg;
        waiting_next  = waiting_reg;
        push          = 1'b0;
        o_kind_next   = o_kind_reg;
        o_amount_next = o_amount_reg;
        if (x_fire)
        begin
            case (x_op_reg)
                OP_WAKE:
                begin
                    if (waiting_reg)
                    begin
                        waiting_next  = 1'b0;
                        ovs_next      = sat32(ovs_wake_w);
                        push          = 1'b1;
                        o_kind_next   = KIND_DONE;
                        o_amount_next = $signed({1'b0, x_elapsed_reg});
                    end
                    else
                    begin
                        o_kind_next   = KIND_IGNORED;
                        o_amount_next = '0;
                    end
                end
                OP_FRAME_END:
                begin
                    waiting_next = 1'b0;
                    if (sleep)
                    begin
                        pending_next  = sat32(adj);
                        waiting_next  = 1'b1;
                        o_kind_next   = KIND_SLEEP;
                        o_amount_next = sat32(adj);
                    end
                    else
                    begin
                        ovs_next      = sat32(ovs_frame_w);
                        push          = 1'b1;
                        o_kind_next   = KIND_DONE;
                        o_amount_next = $signed({1'b0, x_elapsed_reg});
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Error history update on push; the error equals the idle time
    always_comb
    begin
        sum_next    = sum_reg;
        newest_next = newest_reg;
        step_next   = step_reg;
        if (push)
        begin
            sum_next    = sum_reg - SUM_W'($signed(ring_stat.old)) + SUM_W'(x_idle_reg);
            newest_next = x_idle_reg;
            step_next   = 33'(x_idle_reg) - 33'(newest_reg);
        end
    end

    // Register writes
    always_comb
    begin
        period_next = period_reg;
        gain_p_next = gain_p_reg;
        gain_i_next = gain_i_reg;
        gain_d_next = gain_d_reg;
        if (cfg_fire)
        begin
            case (cfg.index)
                REG_FRAME_PERIOD: period_next = cfg.data[TIME_W-1:0];
                REG_GAIN_P:       gain_p_next = $signed(cfg.data);
                REG_GAIN_I:       gain_i_next = $signed(cfg.data);
                REG_GAIN_D:       gain_d_next = $signed(cfg.data);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= PERIOD_RESET;
            gain_p_reg  <= '0;
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
            sum_reg     <= '0;
            newest_reg  <= '0;
            step_reg    <= '0;
            ovs_reg     <= '0;
            pending_reg <= '0;
            waiting_reg <= 1'b0;
            x_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            period_reg  <= period_next;
            gain_p_reg  <= gain_p_next;
            gain_i_reg  <= gain_i_next;
            gain_d_reg  <= gain_d_next;
            sum_reg     <= sum_next;
            newest_reg  <= newest_next;
            step_reg    <= step_next;
            ovs_reg     <= ovs_next;
            pending_reg <= pending_next;
            waiting_reg <= waiting_next;
            if (item_fire)
            begin
                x_valid_reg <= 1'b1;
            end
            else if (x_fire)
            begin
                x_valid_reg <= 1'b0;
            end
            if (x_fire)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            x_op_reg      <= item.op;
            x_elapsed_reg <= item.elapsed;
            x_idle_reg    <= $signed({1'b0, period_reg}) - $signed({1'b0, item.elapsed});
        end
        o_kind_reg   <= o_kind_next;
        o_amount_reg <= o_amount_next;
    end

    assign result.valid  = o_valid_reg;
    assign result.kind   = o_kind_reg;
    assign result.amount = o_amount_reg;

    // Checks
    a_push_stales_terms: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !terms.fresh)
        else $error("gain terms not invalidated after error push");

    a_push_blocks_ring: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !ring_stat.ok)
        else $error("ring read not interlocked after push");

    a_push_needs_ring: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ring_stat.ok)
        else $error("push with stale ring read data");

    a_sleep_waits: assert property (@(posedge clk) disable iff (!rst_n)
        x_fire && x_op_reg == OP_FRAME_END && sleep |=> waiting_reg)
        else $error("sleep request without wake wait");

    a_sleep_positive: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind == KIND_SLEEP
            |-> !result.amount[31] && result.amount != '0)
        else $error("sleep request with non-positive amount");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import fpp_pkg::*;

    localparam int     RING_DEPTH  = WINDOW_DEF;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     HOLD_AT     = 120;
    localparam int     HOLD_CYCLES = 300;
    localparam int     BURST_FROM  = 800;
    localparam int     BURST_TO    = 1100;
    localparam int     PHASE_ITEMS = 150;
    localparam int     MAX_REPORTS = 10;
    localparam longint TIME_MAX    = 64'sh7FFF_FFFF;

    typedef struct {
        logic              op;
        logic [TIME_W-1:0] elapsed;
    } frame_event_t;

    typedef struct {
        logic [1:0]              kind;
        logic signed [AMT_W-1:0] amount;
    } pace_result_t;

    logic clk;
    logic rst_n;

    fpp_item_if   item_ch ();
    fpp_result_if result_ch ();
    fpp_cfg_if    cfg_ch ();

    frame_pacing_pid uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Pacer shadow state
    longint set_point;
    longint kp;
    longint ki;
    longint kd;
    longint err_hist [RING_DEPTH];
    longint err_total;
    longint err_last;
    longint err_delta;
    int     hist_slot;
    longint overshoot;
    longint sleep_ticks;
    bit     wake_due;

    // Stimulus and scoreboard bookkeeping
    frame_event_t frame_events [$];
    frame_event_t next_event;
    pace_result_t predicted [$];
    pace_result_t owed;
    longint       cur_period;
    int           items_sent;
    int           items_taken;
    int           cfg_writes;
    int           settings_count;
    int           fail_count;
    int           n_sleep;
    int           n_done;
    int           n_ignored;
    int           hold_left;
    bit           hold_done;
    int           cycle_count;

    // Clock
    always #1 clk = ~clk;

    function automatic longint clamp_word(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Q16.16 gain times value: magnitude truncated, then saturated to 32 bits
    function automatic longint gain_term(longint g, longint x);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] mag;
        neg = (g < 0) != (x < 0);
        ua  = (g < 0) ? -g : g;
        ub  = (x < 0) ? -x : x;
        mag = ({64'd0, ua} * {64'd0, ub}) >> 16;
        if (neg)
        begin
            if (mag > 128'h8000_0000)
            begin
                return -64'sd2147483648;
            end
            return -longint'(mag[63:0]);
        end
        if (mag > 128'h7FFF_FFFF)
        begin
            return 64'sd2147483647;
        end
        return longint'(mag[63:0]);
    endfunction

    // Push the frame error into the window and refresh sum and step
    function automatic void log_error(longint t);
        longint e;
        e = set_point - t;
        err_total = err_total - err_hist[hist_slot] + e;
        err_hist[hist_slot] = e;
        hist_slot = (hist_slot + 1) % RING_DEPTH;
        err_delta = e - err_last;
        err_last = e;
    endfunction

    function automatic pace_result_t pace_step(logic op, longint t);
        pace_result_t r;
        longint       idle;
        longint       delay;
        longint       adjust;
        if (op == OP_WAKE)
        begin
            if (!wake_due)
            begin
                r.kind   = KIND_IGNORED;
                r.amount = '0;
            end
            else
            begin
                wake_due  = 1'b0;
                overshoot = clamp_word(t - sleep_ticks);
                log_error(t);
                r.kind   = KIND_DONE;
                r.amount = t[31:0];
            end
        end
        else
        begin
            idle  = set_point - t;
            delay = idle + gain_term(kp, err_last) + gain_term(ki, err_total)
                  + gain_term(kd, err_delta);
            // a frame end drops any sleep still pending
            wake_due = 1'b0;
            if (delay > set_point)
            begin
                delay = set_point;
            end
            adjust = delay - overshoot;
            if (adjust > 0)
            begin
                sleep_ticks = clamp_word(adjust);
                wake_due    = 1'b1;
                r.kind      = KIND_SLEEP;
                r.amount    = sleep_ticks[31:0];
            end
            else
            begin
                overshoot = clamp_word(overshoot - idle);
                log_error(t);
                r.kind   = KIND_DONE;
                r.amount = t[31:0];
            end
        end
        return r;
    endfunction

    function automatic void add_item(logic op, longint t);
        frame_event_t ev;
        if (t < 0)
        begin
            t = 0;
        end
        if (t > TIME_MAX)
        begin
            t = TIME_MAX;
        end
        ev.op      = op;
        ev.elapsed = t[TIME_W-1:0];
        frame_events.push_back(ev);
    endfunction

    // Wait until every pending item is through and every result is back
    task automatic settle();
        do
            @(negedge clk);
        while (frame_events.size() != 0 || items_sent != items_taken
               || predicted.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        int target;
        target = cfg_writes + 1;
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        wait (cfg_writes == target);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure(input longint per, input logic [31:0] p,
                             input logic [31:0] i, input logic [31:0] d);
        settle();
        write_reg(REG_FRAME_PERIOD, 32'(per) & 32'h7FFF_FFFF);
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        cur_period = per;
        settings_count++;
    endtask

    // Mostly frame end / wake pairs near the period, plus late frames and noise
    task automatic gen_phase(input int n);
        int     made;
        int     pick;
        longint t1;
        longint t2;
        longint span;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                t1   = longint'($urandom_range(32'(cur_period)));
                span = cur_period / 8 + 1;
                t2   = cur_period + longint'($urandom_range(32'(2 * span))) - span;
                add_item(OP_FRAME_END, t1);
                add_item(OP_WAKE, t2);
                made += 2;
            end
            else if (pick < 82)
            begin
                add_item(OP_FRAME_END, longint'($urandom_range(32'(2 * cur_period + 1))));
                made++;
            end
            else if (pick < 90)
            begin
                add_item(OP_WAKE, longint'($urandom() & 32'h7FFF_FFFF));
                made++;
            end
            else
            begin
                add_item(logic'($urandom_range(1)), longint'($urandom() & 32'h7FFF_FFFF));
                made++;
            end
        end
    endtask

    // Driver: present the next item once the previous transaction is done
    always @(negedge clk)
    begin
        if (rst_n && items_sent == items_taken)
        begin
            if (frame_events.size() != 0
                && ((items_taken >= BURST_FROM && items_taken < BURST_TO)
                    || $urandom_range(99) >= 32))
            begin
                next_event = frame_events.pop_front();
                item_ch.valid   <= 1'b1;
                item_ch.op      <= next_event.op;
                item_ch.elapsed <= next_event.elapsed;
                items_sent++;
            end
            else
            begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // Result ready: random stalls, one long hold-off while items keep coming
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left == 0 && !hold_done && items_taken >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= (items_taken >= BURST_FROM && items_taken < BURST_TO)
                                   || $urandom_range(99) >= 32;
            end
        end
    end

    // Shadow register writes and prediction for each accepted item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_FRAME_PERIOD: set_point = longint'(cfg_ch.data[TIME_W-1:0]);
                    REG_GAIN_P:       kp = longint'($signed(cfg_ch.data));
                    REG_GAIN_I:       ki = longint'($signed(cfg_ch.data));
                    REG_GAIN_D:       kd = longint'($signed(cfg_ch.data));
                    default:          ;
                endcase
                cfg_writes++;
            end
            if (item_ch.valid && item_ch.ready)
            begin
                predicted.push_back(pace_step(item_ch.op, longint'(item_ch.elapsed)));
                items_taken++;
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (predicted.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("unexpected result: kind %0d amount %0d",
                             result_ch.kind, result_ch.amount);
                end
            end
            else
            begin
                owed = predicted.pop_front();
                case (owed.kind)
                    KIND_SLEEP: n_sleep++;
                    KIND_DONE:  n_done++;
                    default:    n_ignored++;
                endcase
                if (result_ch.kind !== owed.kind || result_ch.amount !== owed.amount)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("result differs at %0t: kind exp %0d got %0d, amount exp %0d got %0d",
                                 $realtime, owed.kind, result_ch.kind, owed.amount,
                                 result_ch.amount);
                    end
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.op      = OP_FRAME_END;
        item_ch.elapsed = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_FRAME_PERIOD;
        cfg_ch.data     = '0;

        // Shadow state matches the block after reset
        set_point   = 16667;
        kp          = 0;
        ki          = 0;
        kd          = 0;
        foreach (err_hist[k])
        begin
            err_hist[k] = 0;
        end
        err_total   = 0;
        err_last    = 0;
        err_delta   = 0;
        hist_slot   = 0;
        overshoot   = 0;
        sleep_ticks = 0;
        wake_due    = 1'b0;
        cur_period  = 16667;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset settings: stray wake, sleep and wake, frame end while
        // waiting, overshoot driven into saturation and back
        add_item(OP_WAKE, 0);
        add_item(OP_FRAME_END, 0);
        add_item(OP_WAKE, 17167);
        add_item(OP_FRAME_END, 10000);
        add_item(OP_FRAME_END, 3000);
        add_item(OP_WAKE, 15000);
        add_item(OP_FRAME_END, TIME_MAX);
        add_item(OP_FRAME_END, TIME_MAX);
        add_item(OP_FRAME_END, 0);
        add_item(OP_WAKE, TIME_MAX);
        add_item(OP_FRAME_END, 16667);

        // Directed, full scale period and extreme gains
        configure(TIME_MAX, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_item(OP_FRAME_END, 0);
        add_item(OP_WAKE, TIME_MAX);
        add_item(OP_FRAME_END, 1);
        add_item(OP_WAKE, 0);
        add_item(OP_FRAME_END, TIME_MAX);
        add_item(OP_WAKE, 12345);
        add_item(OP_FRAME_END, 64'h2AAA_AAAA);
        add_item(OP_FRAME_END, 64'h5555_5555);
        add_item(OP_WAKE, 64'h5555_5555);

        // Random phases, one register setting each
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: configure(16667, 32'h0000_4000, 32'h0000_0800, 32'h0000_2000);
                1: configure(16667, 32'h0001_0000, 32'h0000_1000, 32'hFFFF_C000);
                2: configure(1, $urandom(), $urandom(), $urandom());
                3: configure(TIME_MAX, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
                4: configure(0, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
                5: configure(longint'($urandom() & 32'h7FFF_FFFF), $urandom(), $urandom(),
                             $urandom());
                6: configure(1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
                7: configure(33333, 32'hFFFF_0000, 32'hFFFF_F000, 32'h0000_1000);
                8: configure(longint'($urandom_range(100000, 100)),
                             $urandom_range(32'h20000) - 32'h10000,
                             $urandom_range(32'h20000) - 32'h10000,
                             $urandom_range(32'h20000) - 32'h10000);
                default: configure(16667, 32'h0, 32'h0, 32'h0);
            endcase
            gen_phase(PHASE_ITEMS);
        end

        settle();
        repeat (20) @(posedge clk);

        if (predicted.size() != 0)
        begin
            $display("%0d predicted results never arrived", predicted.size());
            fail_count += predicted.size();
        end
        $display("covered %0d item transactions over %0d register settings (reset one too)",
                 items_taken, settings_count);
        $display("%0d sleep requests, %0d frame steps, %0d ignored wakes, %0d failures",
                 n_sleep, n_done, n_ignored, fail_count);
        if (fail_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
